/* rtl/core/cdid_pkg.sv */
// ----------------------------------------------------------------------------
// cdid_pkg: shared types and constants of the disc identifier engine
// Request layout, pipeline stage payload, status codes and fixed arithmetic
// constants used by the bookkeeping and accumulation stages.
// ----------------------------------------------------------------------------
`default_nettype none

package cdid_pkg;

    // Field widths
    localparam int unsigned FRAME_W = 19;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned SECS_W  = 13;
    localparam int unsigned ID_W    = 32;

    // Track limit per disc
    localparam logic [COUNT_W-1:0] MAX_TRACK_COUNT = 7'd99;

    // Request opcodes
    localparam logic OP_TRACK = 1'b0;
    localparam logic OP_CLOSE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_TRACKS = 2'd1,
        STATUS_OVERFLOW  = 2'd2
    } status_t;

    // One incoming request as held in the input register
    typedef struct packed {
        logic               op;
        logic [FRAME_W-1:0] track_offset;
        logic               is_audio;
        logic [FRAME_W-1:0] leadout;
        logic [COUNT_W-1:0] num_audio;
    } req_t;

    // Payload handed from bookkeeping to accumulation
    typedef struct packed {
        logic               op;
        logic [SECS_W-1:0]  secs;        // seconds of track or leadout
        logic [FRAME_W-1:0] frames;      // track offset or leadout
        logic               is_audio;
        logic [ID_W-1:0]    product;     // weighted offset or weighted leadout
        logic [SECS_W-1:0]  first_secs;
        logic [COUNT_W-1:0] tracks;
        status_t            status;
        logic [COUNT_W-1:0] num_audio;
    } stage_t;

endpackage

`default_nettype wire

/* rtl/core/cdid_front.sv */
// ----------------------------------------------------------------------------
// cdid_front: track bookkeeping stage
// Converts frames to seconds, counts tracks and audio rank, applies the
// track limit and forms the one product each request needs.
// ----------------------------------------------------------------------------
`default_nettype none

module cdid_front
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    input  wire cdid_pkg::req_t  req,
    output logic                 req_take,
    output logic                 stage_valid,
    output cdid_pkg::stage_t     stage,
    input  wire logic            stage_take
);
    import cdid_pkg::*;

    localparam int unsigned GAP_FRAMES    = 150;
    localparam int unsigned RECIP_75      = 894785;   // ceil(2^26 / 75)
    localparam int unsigned RECIP_SHIFT   = 26;
    localparam int unsigned SUM_W         = FRAME_W + 1;

    // Frames plus pregap, divided by 75 through a reciprocal multiply
    function automatic logic [SECS_W-1:0] to_seconds(input logic [FRAME_W-1:0] frames);
        logic [SUM_W-1:0]   x;
        logic [2*SUM_W-1:0] p;
        x = {1'b0, frames} + SUM_W'(GAP_FRAMES);
        p = {{SUM_W{1'b0}}, x} * (2*SUM_W)'(RECIP_75);
        return SECS_W'(p >> RECIP_SHIFT);
    endfunction

    logic [COUNT_W-1:0] track_total_reg, track_total_next;
    logic [COUNT_W-1:0] audio_rank_reg, audio_rank_next;
    logic [SECS_W-1:0]  first_secs_reg, first_secs_next;
    logic               seen_reg, seen_next;
    logic               overflow_reg, overflow_next;
    logic               stage_valid_reg, stage_valid_next;
    stage_t             stage_reg;

    logic               stage_ready;
    logic               is_full;
    logic               drop;
    logic               load;
    logic [FRAME_W-1:0] frames;
    logic [SECS_W-1:0]  secs;
    logic [FRAME_W-1:0] mul_a;
    logic [COUNT_W:0]   mul_b;
    logic [FRAME_W+COUNT_W:0] product;
    status_t            close_status;

    // Handshake towards the input register
    assign stage_ready = !stage_valid_reg || stage_take;
    assign req_take    = req_valid && stage_ready;
    assign is_full     = track_total_reg >= MAX_TRACK_COUNT;
    assign drop        = (req.op == OP_TRACK) && is_full;
    assign load        = req_take && !drop;

    // Seconds and the shared multiplier
    assign frames  = (req.op == OP_CLOSE) ? req.leadout : req.track_offset;
    assign secs    = to_seconds(frames);
    always_comb
    begin
        if (req.op == OP_CLOSE)
        begin
            mul_a = req.leadout;
            mul_b = {1'b0, req.num_audio} + (COUNT_W+1)'(1);
        end
        else
        begin
            mul_a = (req.track_offset == '0) ? FRAME_W'(1) : req.track_offset;
            mul_b = {1'b0, audio_rank_reg};
        end
    end
    assign product = {{(COUNT_W+1){1'b0}}, mul_a} * {{FRAME_W{1'b0}}, mul_b};

    // Status on close: no tracks wins over overflow
    always_comb
    begin
        if (!seen_reg)
            close_status = STATUS_NO_TRACKS;
        else if (overflow_reg)
            close_status = STATUS_OVERFLOW;
        else
            close_status = STATUS_OK;
    end

    // Bookkeeping update
    always_comb
    begin
        track_total_next = track_total_reg;
        audio_rank_next  = audio_rank_reg;
        first_secs_next  = first_secs_reg;
        seen_next        = seen_reg;
        overflow_next    = overflow_reg;
        if (req_take)
        begin
            if (req.op == OP_CLOSE)
            begin
                track_total_next = '0;
                audio_rank_next  = COUNT_W'(1);
                first_secs_next  = '0;
                seen_next        = 1'b0;
                overflow_next    = 1'b0;
            end
            else if (is_full)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                if (!seen_reg)
                begin
                    first_secs_next = secs;
                    seen_next       = 1'b1;
                end
                track_total_next = track_total_reg + COUNT_W'(1);
                if (req.is_audio)
                    audio_rank_next = audio_rank_reg + COUNT_W'(1);
            end
        end
    end

    assign stage_valid_next = load ? 1'b1 : (stage_take ? 1'b0 : stage_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_total_reg <= '0;
            audio_rank_reg  <= COUNT_W'(1);
            first_secs_reg  <= '0;
            seen_reg        <= 1'b0;
            overflow_reg    <= 1'b0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            track_total_reg <= track_total_next;
            audio_rank_reg  <= audio_rank_next;
            first_secs_reg  <= first_secs_next;
            seen_reg        <= seen_next;
            overflow_reg    <= overflow_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_reg.op          <= req.op;
            stage_reg.secs        <= secs;
            stage_reg.frames      <= frames;
            stage_reg.is_audio    <= req.is_audio;
            stage_reg.product     <= ID_W'(product);
            stage_reg.first_secs  <= first_secs_reg;
            stage_reg.tracks      <= track_total_reg;
            stage_reg.status      <= close_status;
            stage_reg.num_audio   <= req.num_audio;
        end
    end

    assign stage_valid = stage_valid_reg;
    assign stage       = stage_reg;

endmodule

`default_nettype wire

/* rtl/core/cdid_accum.sv */
// ----------------------------------------------------------------------------
// cdid_accum: accumulation and result stage
// Adds up second digit sums and audio offset sums per track, and on close
// builds the three identifiers into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdid_accum
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          stage_valid,
    input  wire cdid_pkg::stage_t              stage,
    output logic                               stage_take,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [cdid_pkg::ID_W-1:0]          cddb_id,
    output logic [cdid_pkg::ID_W-1:0]          ar_id_one,
    output logic [cdid_pkg::ID_W-1:0]          ar_id_two,
    output logic [cdid_pkg::COUNT_W-1:0]       audio_tracks,
    output logic [1:0]                         status
);
    import cdid_pkg::*;

    localparam int unsigned DIGIT_W     = 12;
    localparam int unsigned DSUM_W      = 6;
    localparam int unsigned RECIP_10    = 6554;    // ceil(2^16 / 10)
    localparam int unsigned R10_SHIFT   = 16;
    localparam int unsigned RECIP_100   = 10486;   // ceil(2^20 / 100)
    localparam int unsigned R100_SHIFT  = 20;
    localparam int unsigned RECIP_1000  = 16778;   // ceil(2^24 / 1000)
    localparam int unsigned R1000_SHIFT = 24;
    localparam int unsigned P10_W       = SECS_W + 15;
    localparam int unsigned MOD_BASE    = 255;
    localparam int unsigned T_W         = 16;

    // Decimal digit sum of a seconds value below 10000; the three quotients
    // are formed side by side so no divide waits on another
    function automatic logic [DSUM_W-1:0] add_digits(input logic [SECS_W-1:0] v);
        logic [P10_W-1:0]  p1;
        logic [P10_W-1:0]  p2;
        logic [P10_W-1:0]  p3;
        logic [SECS_W-1:0] q1;
        logic [SECS_W-1:0] q2;
        logic [SECS_W-1:0] q3;
        logic [3:0]        d0;
        logic [3:0]        d1;
        logic [3:0]        d2;
        logic [3:0]        d3;
        p1 = P10_W'(v) * P10_W'(RECIP_10);
        p2 = P10_W'(v) * P10_W'(RECIP_100);
        p3 = P10_W'(v) * P10_W'(RECIP_1000);
        q1 = SECS_W'(p1 >> R10_SHIFT);
        q2 = SECS_W'(p2 >> R100_SHIFT);
        q3 = SECS_W'(p3 >> R1000_SHIFT);
        d0 = 4'(v - SECS_W'(q1 * SECS_W'(10)));
        d1 = 4'(q1 - SECS_W'(q2 * SECS_W'(10)));
        d2 = 4'(q2 - SECS_W'(q3 * SECS_W'(10)));
        d3 = 4'(q3);
        return DSUM_W'(d0) + DSUM_W'(d1) + DSUM_W'(d2) + DSUM_W'(d3);
    endfunction

    // Modulo 255 of a 12-bit value: 256 folds to 1
    function automatic logic [7:0] mod_255(input logic [DIGIT_W-1:0] d);
        logic [8:0] x;
        x = {1'b0, d[7:0]} + 9'(d[DIGIT_W-1:8]);
        if (x >= 9'(MOD_BASE))
            x = x - 9'(MOD_BASE);
        return x[7:0];
    endfunction

    logic [DIGIT_W-1:0] digit_total_reg, digit_total_next;
    logic [ID_W-1:0]    offset_sum_reg, offset_sum_next;
    logic [ID_W-1:0]    weighted_sum_reg, weighted_sum_next;
    logic               res_valid_reg, res_valid_next;
    logic [ID_W-1:0]    freedb_reg;
    logic [ID_W-1:0]    ar_one_reg;
    logic [ID_W-1:0]    ar_two_reg;
    logic [COUNT_W-1:0] audio_tracks_reg;
    logic [1:0]         status_reg;

    logic               res_free;
    logic               close_take;
    logic [T_W-1:0]     length_secs;
    logic [ID_W-1:0]    fid;

    // Close requests wait for a free result register
    assign res_free   = !res_valid_reg || !out_stall;
    assign stage_take = stage_valid && ((stage.op == OP_TRACK) || res_free);
    assign close_take = stage_take && (stage.op == OP_CLOSE);

    // FreeDB id fields
    assign length_secs = T_W'(stage.secs) - T_W'(stage.first_secs);
    assign fid = {mod_255(digit_total_reg), length_secs, 1'b0, stage.tracks};

    // Accumulators
    always_comb
    begin
        digit_total_next  = digit_total_reg;
        offset_sum_next   = offset_sum_reg;
        weighted_sum_next = weighted_sum_reg;
        if (close_take)
        begin
            digit_total_next  = '0;
            offset_sum_next   = '0;
            weighted_sum_next = '0;
        end
        else if (stage_take)
        begin
            digit_total_next = digit_total_reg + DIGIT_W'(add_digits(stage.secs));
            if (stage.is_audio)
            begin
                offset_sum_next   = offset_sum_reg + ID_W'(stage.frames);
                weighted_sum_next = weighted_sum_reg + stage.product;
            end
        end
    end

    assign res_valid_next = close_take ? 1'b1 : (res_free ? 1'b0 : res_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_total_reg  <= '0;
            offset_sum_reg   <= '0;
            weighted_sum_reg <= '0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            digit_total_reg  <= digit_total_next;
            offset_sum_reg   <= offset_sum_next;
            weighted_sum_reg <= weighted_sum_next;
            res_valid_reg    <= res_valid_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (close_take)
        begin
            freedb_reg       <= fid;
            ar_one_reg       <= offset_sum_reg + ID_W'(stage.frames);
            ar_two_reg       <= weighted_sum_reg + stage.product;
            audio_tracks_reg <= stage.num_audio;
            status_reg       <= stage.status;
        end
    end

    assign out_valid    = res_valid_reg;
    assign cddb_id      = freedb_reg;
    assign ar_id_one    = ar_one_reg;
    assign ar_id_two    = ar_two_reg;
    assign audio_tracks = audio_tracks_reg;
    assign status       = status_reg;

endmodule

`default_nettype wire

/* rtl/core/cd_toc_disc_id_engine.sv */
// Path: a close request's identifiers reach out_valid through the input
//   register, the bookkeeping stage and the result register.
// Throughput: one request per cycle while no stall holds a close back; the
//   frames-to-seconds multiply and the rank multiply sit in the bookkeeping stage, digit sums in the last stage.
// Reset: asynchronous, clears all counters and sums; audio rank restarts at 1.
// ----------------------------------------------------------------------------
// cd_toc_disc_id_engine: CD table-of-contents disc identifier engine
// Collects track entries and on close emits the FreeDB id, both AccurateRip
// ids, the audio track count and a status.
// ----------------------------------------------------------------------------
`default_nettype none

module cd_toc_disc_id_engine
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          op,
    input  wire logic [cdid_pkg::FRAME_W-1:0]  track_offset,
    input  wire logic                          is_audio,
    input  wire logic [cdid_pkg::FRAME_W-1:0]  leadout,
    input  wire logic [cdid_pkg::COUNT_W-1:0]  num_audio,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [cdid_pkg::ID_W-1:0]          cddb_id,
    output logic [cdid_pkg::ID_W-1:0]          ar_id_one,
    output logic [cdid_pkg::ID_W-1:0]          ar_id_two,
    output logic [cdid_pkg::COUNT_W-1:0]       audio_tracks,
    output logic [1:0]                         status
);
    import cdid_pkg::*;

    logic   req_valid_reg, req_valid_next;
    req_t   req_reg;
    logic   req_take;
    logic   in_accept;
    logic   stage_valid;
    stage_t stage;
    logic   stage_take;

    // Input register
    assign in_stall       = req_valid_reg && !req_take;
    assign in_accept      = in_valid && !in_stall;
    assign req_valid_next = in_accept ? 1'b1 : (req_take ? 1'b0 : req_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else
            req_valid_reg <= req_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg.op           <= op;
            req_reg.track_offset <= track_offset;
            req_reg.is_audio     <= is_audio;
            req_reg.leadout      <= leadout;
            req_reg.num_audio    <= num_audio;
        end
    end

    // Bookkeeping stage
    cdid_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid_reg),
        .req         (req_reg),
        .req_take    (req_take),
        .stage_valid (stage_valid),
        .stage       (stage),
        .stage_take  (stage_take)
    );

    // Accumulation and result stage
    cdid_accum u_accum
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage_valid  (stage_valid),
        .stage        (stage),
        .stage_take   (stage_take),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cddb_id      (cddb_id),
        .ar_id_one    (ar_id_one),
        .ar_id_two    (ar_id_two),
        .audio_tracks (audio_tracks),
        .status       (status)
    );

endmodule

`default_nettype wire

/* dv/cd_toc_disc_id_engine_test.sv */
// ----------------------------------------------------------------------------
// cd_toc_disc_id_engine_test: self-checking bench for the disc id engine
// Feeds whole tables of contents (track requests closed by a close request)
// with random idling on both channels. A behavioural model of the id arithmetic
// or a hand-worked row predicts every close result, checked field by field.
// ----------------------------------------------------------------------------
module cd_toc_disc_id_engine_test;

    timeunit 1ns;
    timeprecision 1ps;

    import cdid_pkg::*;

    localparam int unsigned GAP_FRAMES     = 150;
    localparam int unsigned FRAMES_PER_SEC = 75;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned DRAIN_CYCLES   = 16;
    localparam int unsigned TOTAL_ITEMS    = 1850;

    // One set of identifiers as emitted on a close
    typedef struct packed {
        logic [ID_W-1:0]    fid;
        logic [ID_W-1:0]    ar1;
        logic [ID_W-1:0]    ar2;
        logic [COUNT_W-1:0] tracks;
        status_t            st;
    } disc_ids_t;

    // One line of the directed table
    typedef struct {
        logic               op;
        logic [FRAME_W-1:0] off;
        logic               aud;
        logic [FRAME_W-1:0] lead;
        logic [COUNT_W-1:0] cnt;
        logic               known;
        disc_ids_t          ids;
    } toc_row_t;

    logic               clk;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic               op           = OP_TRACK;
    logic [FRAME_W-1:0] track_offset = '0;
    logic               is_audio     = 1'b0;
    logic [FRAME_W-1:0] leadout      = '0;
    logic [COUNT_W-1:0] num_audio    = '0;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic [ID_W-1:0]    cddb_id;
    logic [ID_W-1:0]    ar_id_one;
    logic [ID_W-1:0]    ar_id_two;
    logic [COUNT_W-1:0] audio_tracks;
    logic [1:0]         status;

    // Hand-worked expectation travelling alongside the request
    logic               row_known    = 1'b0;
    disc_ids_t          row_ids      = '0;

    // Shared bench control
    logic               no_idle      = 1'b0;
    logic               sink_hold    = 1'b0;
    int unsigned        items_sent   = 0;
    int unsigned        mismatch_count = 0;
    int unsigned        idle_run     = 0;
    disc_ids_t          pending_ids[$];
    toc_row_t           toc_table[$];

    // Model state of the disc being collected
    logic [11:0]        dig_acc    = '0;
    logic [COUNT_W-1:0] trk_cnt    = '0;
    logic [SECS_W-1:0]  first_sec  = '0;
    logic               have_track = 1'b0;
    logic               too_many   = 1'b0;
    logic [ID_W-1:0]    ar_sum     = '0;
    logic [ID_W-1:0]    ar_wsum    = '0;
    logic [COUNT_W-1:0] rank       = 7'd1;

    cd_toc_disc_id_engine dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .track_offset (track_offset),
        .is_audio     (is_audio),
        .leadout      (leadout),
        .num_audio    (num_audio),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cddb_id      (cddb_id),
        .ar_id_one    (ar_id_one),
        .ar_id_two    (ar_id_two),
        .audio_tracks (audio_tracks),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Frames plus pregap, truncated to whole seconds
    function automatic logic [SECS_W-1:0] frames_to_secs(input logic [FRAME_W-1:0] frames);
        logic [31:0] s;
        s = ({13'd0, frames} + GAP_FRAMES) / FRAMES_PER_SEC;
        return s[SECS_W-1:0];
    endfunction

    // Decimal digit sum over five digits
    function automatic logic [5:0] add_digits(input logic [SECS_W-1:0] v);
        int unsigned rest;
        int unsigned acc;
        rest = 32'(v);
        acc  = 0;
        repeat (5)
        begin
            acc  += rest % 10;
            rest /= 10;
        end
        return acc[5:0];
    endfunction

    // Advance the model by one request; a close yields the disc identifiers
    task automatic compute_disc_ids(input logic op_in, input logic [FRAME_W-1:0] off_in,
                                    input logic aud_in, input logic [FRAME_W-1:0] lead_in,
                                    input logic [COUNT_W-1:0] cnt_in,
                                    output logic made, output disc_ids_t ids);
        logic [SECS_W-1:0] secs;
        logic [15:0]       span;
        logic [11:0]       folded;
        logic [ID_W-1:0]   weight;
        made = 1'b0;
        ids  = '0;
        if (op_in == OP_TRACK)
        begin
            // past the track limit the entry is dropped but remembered
            if (trk_cnt >= MAX_TRACK_COUNT)
                too_many = 1'b1;
            else
            begin
                secs    = frames_to_secs(off_in);
                dig_acc = dig_acc + 12'(add_digits(secs));
                if (!have_track)
                begin
                    first_sec  = secs;
                    have_track = 1'b1;
                end
                trk_cnt = trk_cnt + 7'd1;
                if (aud_in)
                begin
                    weight  = (off_in == '0) ? 32'd1 : {13'd0, off_in};
                    ar_sum  = ar_sum + {13'd0, off_in};
                    ar_wsum = ar_wsum + weight * {25'd0, rank};
                    rank    = rank + 7'd1;
                end
            end
        end
        else
        begin
            span       = {3'd0, frames_to_secs(lead_in)} - {3'd0, first_sec};
            folded     = dig_acc % 12'd255;
            ids.fid    = {folded[7:0], span, 1'b0, trk_cnt};
            ids.ar1    = ar_sum + {13'd0, lead_in};
            ids.ar2    = ar_wsum + {13'd0, lead_in} * ({25'd0, cnt_in} + 32'd1);
            ids.tracks = cnt_in;
            // no tracks wins over overflow
            ids.st     = !have_track ? STATUS_NO_TRACKS
                       : (too_many ? STATUS_OVERFLOW : STATUS_OK);
            made       = 1'b1;
            dig_acc    = '0;
            trk_cnt    = '0;
            first_sec  = '0;
            have_track = 1'b0;
            too_many   = 1'b0;
            ar_sum     = '0;
            ar_wsum    = '0;
            rank       = 7'd1;
        end
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s mismatch, expected %h got %h", $realtime, field, want, got);
    endtask

    // Check results first, then predict from the request taken at this edge
    always @(posedge clk)
    begin
        disc_ids_t want;
        disc_ids_t made_ids;
        logic      made;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_ids.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with nothing expected, cddb_id %h",
                             $realtime, cddb_id);
            end
            else
            begin
                want = pending_ids.pop_front();
                if (cddb_id !== want.fid)
                    report_mismatch("cddb_id", want.fid, cddb_id);
                if (ar_id_one !== want.ar1)
                    report_mismatch("ar_id_one", want.ar1, ar_id_one);
                if (ar_id_two !== want.ar2)
                    report_mismatch("ar_id_two", want.ar2, ar_id_two);
                if (audio_tracks !== want.tracks)
                    report_mismatch("audio_tracks", {25'd0, want.tracks}, {25'd0, audio_tracks});
                if (status !== want.st)
                    report_mismatch("status", {30'd0, want.st}, {30'd0, status});
            end
        end
        if (rst_n && in_valid && !in_stall)
        begin
            compute_disc_ids(op, track_offset, is_audio, leadout, num_audio, made, made_ids);
            if (made)
                pending_ids.push_back(row_known ? row_ids : made_ids);
        end
    end

    // Watchdog: too long without any request or result moving
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_run <= 0;
        else if (idle_run >= WATCHDOG_LIMIT)
        begin
            $display("cd_toc_disc_id_engine test failed");
            $finish;
        end
        else
            idle_run <= idle_run + 1;
    end

    // Result side: random stalls, one long hold on request
    initial
    begin
        int unsigned wait_cycles;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (sink_hold)
            begin
                wait_cycles = HOLD_CYCLES;
                sink_hold   = 1'b0;
            end
            else if (no_idle)
                wait_cycles = 0;
            else
                wait_cycles = $urandom_range(0, 12);
            if (wait_cycles != 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Offer one request after a random gap and hold it until taken
    task automatic offer(input logic op_in, input logic [FRAME_W-1:0] off_in, input logic aud_in,
                         input logic [FRAME_W-1:0] lead_in, input logic [COUNT_W-1:0] cnt_in,
                         input logic known, input disc_ids_t ids);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= op_in;
        track_offset <= off_in;
        is_audio     <= aud_in;
        leadout      <= lead_in;
        num_audio    <= cnt_in;
        row_known    <= known;
        row_ids      <= ids;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic plan(input logic op_in, input logic [FRAME_W-1:0] off_in, input logic aud_in,
                        input logic [FRAME_W-1:0] lead_in, input logic [COUNT_W-1:0] cnt_in,
                        input logic known, input logic [31:0] fid, input logic [31:0] ar1,
                        input logic [31:0] ar2, input status_t st);
        toc_row_t r;
        r.op         = op_in;
        r.off        = off_in;
        r.aud        = aud_in;
        r.lead       = lead_in;
        r.cnt        = cnt_in;
        r.known      = known;
        r.ids.fid    = fid;
        r.ids.ar1    = ar1;
        r.ids.ar2    = ar2;
        r.ids.tracks = cnt_in;
        r.ids.st     = st;
        toc_table.push_back(r);
    endtask

    initial
    begin
        toc_row_t           r;
        int unsigned        disc_no;
        int unsigned        kind;
        int unsigned        ntr;
        int unsigned        n_audio;
        logic [FRAME_W-1:0] pos;
        logic               aud;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: op, offset, audio, leadout, count, known, ids
        // empty disc at both leadout extremes
        plan(OP_CLOSE, 19'd0, 1'b0, 19'd0, 7'd0, 1'b1,
             32'h00000200, 32'h0, 32'h0, STATUS_NO_TRACKS);
        plan(OP_CLOSE, 19'h7FFFF, 1'b1, 19'h7FFFF, 7'd99, 1'b1,
             32'h001B5000, 32'h0007FFFF, 32'h031FFF9C, STATUS_NO_TRACKS);
        // single audio track at frame zero: weight clamped to one
        plan(OP_TRACK, 19'd0, 1'b1, 19'h7FFFF, 7'd99, 1'b0, 32'h0, 32'h0, 32'h0, STATUS_OK);
        plan(OP_CLOSE, 19'h7FFFF, 1'b0, 19'd0, 7'd1, 1'b1,
             32'h02000001, 32'h0, 32'h1, STATUS_OK);
        // leadout ahead of the first track wraps the length field
        plan(OP_TRACK, 19'h7FFFF, 1'b0, 19'd0, 7'd0, 1'b0, 32'h0, 32'h0, 32'h0, STATUS_OK);
        plan(OP_CLOSE, 19'd0, 1'b0, 19'd0, 7'd0, 1'b1,
             32'h1AE4B201, 32'h0, 32'h0, STATUS_OK);
        // mixed disc, ignored fields on track requests at their maxima or at zero
        plan(OP_TRACK, 19'd0, 1'b1, 19'h7FFFF, 7'd99, 1'b0, 32'h0, 32'h0, 32'h0, STATUS_OK);
        plan(OP_TRACK, 19'd17000, 1'b0, 19'h7FFFF, 7'd99, 1'b0, 32'h0, 32'h0, 32'h0, STATUS_OK);
        plan(OP_TRACK, 19'd35000, 1'b1, 19'd0, 7'd0, 1'b0, 32'h0, 32'h0, 32'h0, STATUS_OK);
        plan(OP_TRACK, 19'd52000, 1'b1, 19'd0, 7'd0, 1'b0, 32'h0, 32'h0, 32'h0, STATUS_OK);
        plan(OP_CLOSE, 19'd0, 1'b0, 19'd80000, 7'd3, 1'b0, 32'h0, 32'h0, 32'h0, STATUS_OK);
        // largest offsets, audio count not matching the entries
        plan(OP_TRACK, 19'h7FFFF, 1'b1, 19'd0, 7'd0, 1'b0, 32'h0, 32'h0, 32'h0, STATUS_OK);
        plan(OP_TRACK, 19'h7FFFF, 1'b1, 19'd0, 7'd0, 1'b0, 32'h0, 32'h0, 32'h0, STATUS_OK);
        plan(OP_CLOSE, 19'h7FFFF, 1'b1, 19'h7FFFF, 7'd99, 1'b0, 32'h0, 32'h0, 32'h0, STATUS_OK);
        plan(OP_TRACK, 19'd150, 1'b1, 19'd0, 7'd0, 1'b0, 32'h0, 32'h0, 32'h0, STATUS_OK);
        plan(OP_CLOSE, 19'd0, 1'b0, 19'd100, 7'd7, 1'b0, 32'h0, 32'h0, 32'h0, STATUS_OK);

        foreach (toc_table[i])
        begin
            r = toc_table[i];
            offer(r.op, r.off, r.aud, r.lead, r.cnt, r.known, r.ids);
        end

        // Back-to-back closes against a long result hold: fills the pipe
        no_idle   = 1'b1;
        sink_hold = 1'b1;
        repeat (40)
            offer(OP_CLOSE, FRAME_W'($urandom), 1'($urandom_range(0, 1)), FRAME_W'($urandom),
                  COUNT_W'($urandom_range(0, 99)), 1'b0, '0);

        // Random discs: mostly well formed, some broken, some noise
        disc_no = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            disc_no++;
            no_idle = (disc_no % 12) < 2;
            kind    = $urandom_range(0, 9);
            if (disc_no % 40 == 5)
                ntr = 32'(MAX_TRACK_COUNT) + $urandom_range(1, 4);
            else if (disc_no % 40 == 25)
                ntr = 32'(MAX_TRACK_COUNT);
            else if (kind == 0)
                ntr = 0;
            else
                ntr = $urandom_range(1, 16);

            if (kind == 9)
            begin
                // noise: arbitrary requests in any order
                repeat ($urandom_range(1, 6))
                    offer(1'($urandom_range(0, 1)), FRAME_W'($urandom),
                          1'($urandom_range(0, 1)), FRAME_W'($urandom),
                          COUNT_W'($urandom_range(0, 99)), 1'b0, '0);
            end
            else
            begin
                pos     = ($urandom_range(0, 3) == 0) ? '0 : FRAME_W'($urandom_range(0, 40000));
                n_audio = 0;
                for (int unsigned t = 0; t < ntr; t++)
                begin
                    aud = ($urandom_range(0, 4) != 0);
                    if (aud)
                        n_audio++;
                    offer(OP_TRACK, pos, aud, FRAME_W'($urandom),
                          COUNT_W'($urandom_range(0, 99)), 1'b0, '0);
                    pos = pos + ((ntr > 16) ? FRAME_W'($urandom_range(1, 5000))
                                            : FRAME_W'($urandom_range(1, 30000)));
                end
                if (n_audio > 32'(MAX_TRACK_COUNT))
                    n_audio = 32'(MAX_TRACK_COUNT);
                // broken discs: wild leadout or wrong audio count
                offer(OP_CLOSE, FRAME_W'($urandom), 1'($urandom_range(0, 1)),
                      (kind == 1) ? FRAME_W'($urandom)
                                  : pos + FRAME_W'($urandom_range(0, 20000)),
                      (kind == 2) ? COUNT_W'($urandom_range(0, 99)) : COUNT_W'(n_audio),
                      1'b0, '0);
            end
        end

        // Let the last prediction land, then drain
        in_valid <= 1'b0;
        no_idle  = 1'b0;
        @(posedge clk);
        while (pending_ids.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_ids.size() == 0)
            $display("cd_toc_disc_id_engine test passed");
        else
            $display("cd_toc_disc_id_engine test failed");
        $finish;
    end

endmodule

/* cd_toc_disc_id_engine.f */
rtl/core/cdid_pkg.sv
rtl/core/cdid_front.sv
rtl/core/cdid_accum.sv
rtl/core/cd_toc_disc_id_engine.sv
dv/cd_toc_disc_id_engine_test.sv
